// ----- rtl/core/assert_macros.svh -----
// Assertion helpers; expect clk and rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fdsw_pkg.sv -----
`default_nettype none

package fdsw_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [13:0] MAX_VALUE = 14'd9999;
  localparam logic [7:0]  CMD_ADDR  = 8'h48;
  localparam logic [7:0]  BLANK_SEG = 8'h00;
  localparam logic [7:0]  POINT_BIT = 8'h80;

  typedef enum logic [1:0] {
    REQ_SHOW  = 2'd0,
    REQ_CTRL  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // classified word handed from front to back
  typedef struct packed {
    req_t        kind;
    logic [13:0] value;  // saturated
    logic [1:0]  dp;     // 0 none, else point after digit dp
    logic [7:0]  ctrl;   // control byte
  } word_t;

  // queue read side
  typedef struct packed {
    logic  empty;
    word_t head;
  } qrd_t;

  // one bus write
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
  } wr_t;

  localparam logic [7:0] DIGIT_ADDR [4] = '{8'h68, 8'h6A, 8'h6C, 8'h6E};

  // k times the place value of each digit position, left to right
  localparam logic [13:0] PLACE_MULT [4][10] = '{
    '{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
      14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000},
    '{14'd0, 14'd100, 14'd200, 14'd300, 14'd400,
      14'd500, 14'd600, 14'd700, 14'd800, 14'd900},
    '{14'd0, 14'd10, 14'd20, 14'd30, 14'd40,
      14'd50, 14'd60, 14'd70, 14'd80, 14'd90},
    '{14'd0, 14'd1, 14'd2, 14'd3, 14'd4,
      14'd5, 14'd6, 14'd7, 14'd8, 14'd9}
  };

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = BLANK_SEG;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fdsw_front.sv -----
`default_nettype none

module fdsw_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic          full,
  input  wire logic [1:0]    req_type,
  input  wire logic [13:0]   number,
  input  wire logic [2:0]    dp_position,
  input  wire logic          display_on,
  input  wire logic          brightness_wr_en,
  input  wire logic [2:0]    brightness_wr_data,
  output fdsw_pkg::word_t    word,
  output logic               word_valid
);
  import fdsw_pkg::*;

  logic [2:0] brightness;
  logic [2:0] level;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= 3'd0;
    end else if (brightness_wr_en) begin
      brightness <= brightness_wr_data;
    end
  end

  assign level = brightness + 3'd1;  // wraps mod 8

  always_comb begin
    word.kind  = req_t'(req_type);
    word.value = (number > MAX_VALUE) ? MAX_VALUE : number;
    word.dp    = (dp_position inside {[3'd1:3'd3]}) ? dp_position[1:0] : 2'd0;
    word.ctrl  = {1'b0, level, 3'b000, display_on};
  end

  // unknown request type is taken and dropped
  assign word_valid = push && !full && (req_t'(req_type) != REQ_NONE);

endmodule

`default_nettype wire

// ----- rtl/core/fdsw_queue.sv -----
`default_nettype none

module fdsw_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire fdsw_pkg::word_t wr_word,
  input  wire logic          rd_en,
  output fdsw_pkg::qrd_t     rd,
  output logic               full
);
  import fdsw_pkg::*;

  word_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && (count != '0);

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rd.empty = (count == '0);
  assign rd.head  = mem[rd_ptr];

endmodule

`default_nettype wire

// ----- rtl/core/fdsw_back.sv -----
`default_nettype none

module fdsw_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fdsw_pkg::qrd_t rd,
  output logic               rd_en,
  input  wire logic          pop,
  output logic               empty,
  output fdsw_pkg::wr_t      out_wr
);
  import fdsw_pkg::*;

  // sequencer state
  logic        busy;
  logic [1:0]  pos;
  word_t       held;
  logic [13:0] rem;
  logic        blanking;
  logic        out_valid;

  logic        busy_next;
  logic [1:0]  pos_next;
  logic [13:0] rem_next;
  logic        blanking_next;

  // current write
  word_t       cur;
  logic [1:0]  cur_pos;
  logic [13:0] cur_rem;
  logic        cur_blank;
  logic        can_emit;
  logic        emit;
  logic [3:0]  digit;
  logic        has_point;
  wr_t         wr;

  assign cur       = busy ? held : rd.head;
  assign cur_pos   = busy ? pos : 2'd0;
  assign cur_rem   = busy ? rem : rd.head.value;
  assign cur_blank = busy ? blanking : 1'b1;

  assign can_emit = !out_valid || pop;
  assign emit     = can_emit && (busy || !rd.empty);
  assign rd_en    = emit && !busy;

  // digit by parallel compares against the place multiples
  always_comb begin
    digit = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (cur_rem >= PLACE_MULT[cur_pos][k]) begin
        digit = 4'(k);
      end
    end
  end

  assign has_point = (cur.dp != 2'd0) && ({1'b0, cur.dp} == {1'b0, cur_pos} + 3'd1);

  always_comb begin
    wr            = '0;
    blanking_next = cur_blank;
    case (cur.kind)
      REQ_SHOW: begin
        wr.addr = DIGIT_ADDR[cur_pos];
        wr.last = (cur_pos == 2'd3);
        if (cur_blank && (digit == 4'd0) && !has_point) begin
          wr.data = BLANK_SEG;
        end else begin
          blanking_next = 1'b0;
          wr.data = seg_code(digit) | (has_point ? POINT_BIT : BLANK_SEG);
        end
      end
      REQ_CLEAR: begin
        wr.addr = DIGIT_ADDR[cur_pos];
        wr.data = BLANK_SEG;
        wr.last = (cur_pos == 2'd3);
      end
      REQ_CTRL: begin
        wr.addr = CMD_ADDR;
        wr.data = cur.ctrl;
        wr.last = 1'b1;
      end
      default: begin
        wr.addr = CMD_ADDR;
        wr.data = BLANK_SEG;
        wr.last = 1'b1;
      end
    endcase
  end

  assign busy_next = emit ? !wr.last : busy;
  assign pos_next  = cur_pos + 2'd1;
  assign rem_next  = cur_rem - PLACE_MULT[cur_pos][digit];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      if (can_emit) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      held     <= cur;
      pos      <= pos_next;
      rem      <= rem_next;
      blanking <= blanking_next;
      out_wr   <= wr;
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire

// ----- rtl/core/four_digit_segment_display_writer_core.sv -----
// Channel   Handshake              Payload
// input     push / full            req_type, number, dp_position, display_on
// result    empty / pop            bus_address, bus_data, last_write
// config    brightness_wr_en       brightness_wr_data (brightness level)
//
// Input takes one word per cycle while full is low; a 2-entry queue sits
// between the classifying front and the write sequencer.
// Show and clear give 4 writes, control gives 1, one write per cycle while
// pop keeps up; the rate is bounded by the single write register.
// An accepted word passes the queue, then the write register, to the result ports.
// A held result (pop low) stalls only the sequencer; the queue keeps filling.
// Synchronous reset empties queue and sequencer, brightness returns to 0.
`default_nettype none

module four_digit_segment_display_writer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type,
  input  wire logic [13:0] number,
  input  wire logic [2:0]  dp_position,
  input  wire logic        display_on,
  input  wire logic        brightness_wr_en,
  input  wire logic [2:0]  brightness_wr_data,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       bus_address,
  output logic [7:0]       bus_data,
  output logic             last_write
);
  import fdsw_pkg::*;

  word_t front_word;
  logic  front_valid;
  qrd_t  q_rd;
  logic  q_rd_en;
  wr_t   out_wr;

  // front: saturate, normalize point, build control byte
  fdsw_front u_front (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .req_type           (req_type),
    .number             (number),
    .dp_position        (dp_position),
    .display_on         (display_on),
    .brightness_wr_en   (brightness_wr_en),
    .brightness_wr_data (brightness_wr_data),
    .word               (front_word),
    .word_valid         (front_valid)
  );

  // decoupling queue; full gates acceptance for every request type
  fdsw_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_word (front_word),
    .rd_en   (q_rd_en),
    .rd      (q_rd),
    .full    (full)
  );

  // back: digit split one position per write, blanking, segment mapping
  fdsw_back u_back (
    .clk    (clk),
    .rst    (rst),
    .rd     (q_rd),
    .rd_en  (q_rd_en),
    .pop    (pop),
    .empty  (empty),
    .out_wr (out_wr)
  );

  assign bus_address = out_wr.addr;
  assign bus_data    = out_wr.data;
  assign last_write  = out_wr.last;

endmodule

`default_nettype wire

// ----- rtl/core/fdsw_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module fdsw_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] bus_address,
  input wire logic [7:0] bus_data,
  input wire logic       last_write
);
  import fdsw_pkg::*;

  logic        stalled;
  logic [16:0] result_word;
  logic        last_addr;
  logic        addr_ok;
  logic        right_digit;

  assign stalled     = !empty && !pop;
  assign result_word = {bus_address, bus_data, last_write};
  assign right_digit = (bus_address == DIGIT_ADDR[3]);
  assign last_addr   = (bus_address == CMD_ADDR) || right_digit;
  assign addr_ok     = last_addr || (bus_address == DIGIT_ADDR[0]) ||
                       (bus_address == DIGIT_ADDR[1]) || (bus_address == DIGIT_ADDR[2]);

  `ASSERT_NEXT(a_hold, stalled, !empty && $stable(result_word), "word changed while stalled")

  `ASSERT_IMPLIES(a_addr, !empty, addr_ok, "bad bus address")

  `ASSERT_IMPLIES(a_last, !empty, last_write == last_addr, "last flag out of place")

  `ASSERT_IMPLIES(a_point, !empty && right_digit, !bus_data[7], "point on rightmost digit")

endmodule

bind four_digit_segment_display_writer_core fdsw_checker u_fdsw_checker (.*);

`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none

// Self-checking bench for the four-digit display writer core.
// Each word pushed in is run through a local model of the display encoding.
// The model queues the bus writes it expects. A receiver process pops
// results under random back-pressure and compares every field, in order,
// with the oldest queued write.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fdsw_pkg::*;

  // Run control.
  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 60;     // long receiver stall, fills the queue
  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PCT      = 36;
  localparam int REPORT_MAX    = 10;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_WORDS   = 45;

  // Segment font for digits 0..9, bit 7 is the point.
  localparam logic [7:0] SEG_FONT [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  logic        clk;
  logic        rst                = 1'b1;
  logic        push               = 1'b0;
  logic        full;
  logic [1:0]  req_type           = REQ_SHOW;
  logic [13:0] number             = '0;
  logic [2:0]  dp_position        = '0;
  logic        display_on         = 1'b0;
  logic        brightness_wr_en   = 1'b0;
  logic [2:0]  brightness_wr_data = '0;
  logic        empty;
  logic        pop                = 1'b0;
  logic [7:0]  bus_address;
  logic [7:0]  bus_data;
  logic        last_write;

  four_digit_segment_display_writer_core u_top (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .req_type           (req_type),
    .number             (number),
    .dp_position        (dp_position),
    .display_on         (display_on),
    .brightness_wr_en   (brightness_wr_en),
    .brightness_wr_data (brightness_wr_data),
    .empty              (empty),
    .pop                (pop),
    .bus_address        (bus_address),
    .bus_data           (bus_data),
    .last_write         (last_write)
  );

  // Bench state: local copy of the brightness register and the writes
  // still owed by the block, oldest first.
  logic [2:0] brightness_model = '0;
  wr_t        display_writes[$];
  int         mismatches = 0;
  int         cycles     = 0;
  int         send_idle_pct = IDLE_PCT;
  int         recv_idle_pct = IDLE_PCT;
  bit         hold_trigger  = 1'b0;
  int         hold_left     = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Model of the encoder: queue the bus writes one accepted word causes.
  task automatic predict_writes(input req_t kind, input logic [13:0] value,
                                input logic [2:0] dp, input logic on);
    int         digit[4];
    int         point;
    bit         blanking;
    logic [7:0] seg;
    logic [2:0] level;
    case (kind)
      REQ_SHOW: begin
        if (value > MAX_VALUE) value = MAX_VALUE;
        point    = (dp > 3) ? 0 : int'(dp);
        digit[0] = value / 1000;
        digit[1] = (value / 100) % 10;
        digit[2] = (value / 10) % 10;
        digit[3] = value % 10;
        blanking = 1'b1;
        for (int i = 0; i < 4; i++) begin
          // leading zeros stay dark until a nonzero digit or the point digit
          if (blanking && digit[i] == 0 && point != i + 1) begin
            seg = BLANK_SEG;
          end else begin
            blanking = 1'b0;
            seg = SEG_FONT[digit[i]];
            if (point == i + 1) seg = seg | POINT_BIT;
          end
          display_writes.push_back('{addr: DIGIT_ADDR[i], data: seg, last: (i == 3)});
        end
      end
      REQ_CTRL: begin
        level = brightness_model + 3'd1;  // wraps mod 8
        display_writes.push_back('{addr: CMD_ADDR, data: {1'b0, level, 3'b000, on},
                                   last: 1'b1});
      end
      REQ_CLEAR: begin
        for (int i = 0; i < 4; i++)
          display_writes.push_back('{addr: DIGIT_ADDR[i], data: BLANK_SEG, last: (i == 3)});
      end
      default: begin
        // unknown request: dropped, nothing written
      end
    endcase
  endtask

  // Offer one word and return at the edge that accepts it. Push is left
  // high so a following word goes out back to back; callers that stop
  // sending lower it through wait_idle.
  task automatic send_word(input req_t kind, input logic [13:0] value,
                           input logic [2:0] dp, input logic on);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    req_type    <= kind;
    number      <= value;
    dp_position <= dp;
    display_on  <= on;
    do @(posedge clk); while (full);
    predict_writes(kind, value, dp, on);
  endtask

  // Stop sending, let every owed write come out, then let the pipe settle
  // (a dropped request leaves nothing in the queue to wait on).
  task automatic wait_idle();
    push <= 1'b0;
    while (display_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_brightness(input logic [2:0] level);
    wait_idle();
    brightness_wr_en   <= 1'b1;
    brightness_wr_data <= level;
    @(posedge clk);
    brightness_model = level;
    brightness_wr_en <= 1'b0;
  endtask

  // Random word: half are show requests, with numbers spread over small,
  // mid, saturating and boundary ranges.
  task automatic send_random_word();
    req_t        kind;
    logic [13:0] value;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: kind = REQ_SHOW;
      5, 6:          kind = REQ_CTRL;
      7, 8:          kind = REQ_CLEAR;
      default:       kind = REQ_NONE;
    endcase
    case ($urandom_range(9))
      0, 1, 2: value = 14'($urandom);
      3, 4, 5: value = 14'($urandom_range(9999));
      6, 7:    value = 14'($urandom_range(99));
      8:       value = 14'($urandom_range(9));
      default: value = 14'($urandom_range(10001, 9998));
    endcase
    send_word(kind, value, 3'($urandom), 1'($urandom));
  endtask

  // Receiver: check the word on the result ports when it is popped, then
  // pick pop for the next edge. A hold request stalls it.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (display_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected write: addr %h data %h last %b",
                     bus_address, bus_data, last_write);
        end else begin
          wr_t exp_wr;
          exp_wr = display_writes.pop_front();
          if (bus_address !== exp_wr.addr || bus_data !== exp_wr.data ||
              last_write !== exp_wr.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("write mismatch: expected addr %h data %h last %b, got %h %h %b",
                       exp_wr.addr, exp_wr.data, exp_wr.last,
                       bus_address, bus_data, last_write);
          end
        end
      end
      if (hold_trigger) begin
        hold_left    = HOLD_CYCLES;
        hold_trigger = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Control byte straight out of reset, brightness 0 -> level field 1.
  task automatic test_reset_control();
    send_word(REQ_CTRL, 14'd0, 3'd0, 1'b1);
    send_word(REQ_CTRL, 14'h3FFF, 3'd7, 1'b0);
  endtask

  // Saturation, blanking and point placement corners.
  task automatic test_show_corners();
    send_word(REQ_SHOW, 14'd0, 3'd0, 1'b0);     // zero, no point: all dark
    send_word(REQ_SHOW, 14'd0, 3'd1, 1'b1);     // point on leading zero
    send_word(REQ_SHOW, 14'd0, 3'd3, 1'b0);
    send_word(REQ_SHOW, 14'd5, 3'd2, 1'b0);
    send_word(REQ_SHOW, 14'd7, 3'd4, 1'b0);     // point out of range -> none
    send_word(REQ_SHOW, 14'd10, 3'd7, 1'b1);
    send_word(REQ_SHOW, 14'd100, 3'd0, 1'b0);
    send_word(REQ_SHOW, 14'd1000, 3'd0, 1'b0);
    send_word(REQ_SHOW, 14'd1005, 3'd3, 1'b0);
    send_word(REQ_SHOW, 14'd9999, 3'd1, 1'b0);
    send_word(REQ_SHOW, 14'd10000, 3'd2, 1'b0); // saturates
    send_word(REQ_SHOW, 14'h3FFF, 3'd5, 1'b1);
    send_word(REQ_SHOW, 14'd1234, 3'd6, 1'b0);
  endtask

  // Clear ignores its payload; request code 3 writes nothing.
  task automatic test_clear_and_unknown();
    send_word(REQ_CLEAR, 14'h3FFF, 3'd7, 1'b1);
    send_word(REQ_NONE, 14'd4321, 3'd2, 1'b1);
    send_word(REQ_CLEAR, 14'd0, 3'd0, 1'b0);
    send_word(REQ_NONE, 14'd0, 3'd0, 1'b0);
    send_word(REQ_SHOW, 14'd42, 3'd0, 1'b0);
  endtask

  // Brightness extremes, including 7 whose level field wraps to 0.
  task automatic test_brightness_extremes();
    set_brightness(3'd7);
    send_word(REQ_CTRL, 14'd0, 3'd0, 1'b1);
    send_word(REQ_CTRL, 14'd0, 3'd0, 1'b0);
    set_brightness(3'd0);
    send_word(REQ_CTRL, 14'd0, 3'd0, 1'b1);
  endtask

  // Receiver stalls while the sender keeps pushing: the queue fills and
  // full must hold words back; then the sender waits for the drain.
  task automatic test_backpressure();
    wait_idle();
    send_idle_pct = 0;
    hold_trigger  = 1'b1;
    repeat (12) send_word(REQ_SHOW, 14'($urandom), 3'($urandom), 1'($urandom));
    wait_idle();
    send_idle_pct = IDLE_PCT;
  endtask

  // Random phases, each at its own brightness; one phase with no idling.
  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_brightness((p == 0) ? 3'd7 : 3'($urandom));
      if (p == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
      end
      repeat (PHASE_WORDS) send_random_word();
    end
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_control();
    test_show_corners();
    test_clear_and_unknown();
    test_brightness_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
